// ----- rtl/most_frequent_substring_finder_macros.svh -----
// ----------------------------------------------------------------------------
// Most frequent substring finder: assertion macros
// Shorthand for the clocked implication checks used at the top level.
// ----------------------------------------------------------------------------
`ifndef MOST_FREQUENT_SUBSTRING_FINDER_MACROS_SVH
`define MOST_FREQUENT_SUBSTRING_FINDER_MACROS_SVH

// same-cycle implication
`define MFSF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("mfsf: same-cycle check failed");

// next-cycle implication
`define MFSF_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("mfsf: next-cycle check failed");

`endif

// ----- rtl/mfsf_pkg.sv -----
// ----------------------------------------------------------------------------
// Most frequent substring finder: package
// Shared types and fixed constants for the front end, queue and search engine.
// ----------------------------------------------------------------------------
`default_nettype none

package mfsf_pkg;

    localparam int SYM_W      = 8;
    localparam int GRP_W      = 8;
    localparam int GRP_CNT_W  = 4;
    localparam int QDEPTH     = 4;
    localparam int QPW        = $clog2(QDEPTH);

    typedef logic [SYM_W-1:0] t_sym;

    // one queued transaction for the search engine
    typedef struct packed {
        logic wr;
        logic seq_end;
        logic ovf;
        t_sym sym;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_LOAD,
        ST_STEP,
        ST_DRAIN,
        ST_FINISH
    } t_srch_state;

endpackage

`default_nettype wire

// ----- rtl/mfsf_front.sv -----
// ----------------------------------------------------------------------------
// Most frequent substring finder: front end
// Takes input transactions, tracks fill level and overflow, and queues
// store writes and end-of-sequence commands for the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mfsf_front #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_symbol,
    input  wire logic                   i_last_symbol,
    input  wire mfsf_pkg::t_q_stat      i_q_stat,
    output logic                        o_push,
    output mfsf_pkg::t_cmd              o_cmd
);
    import mfsf_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_fill;
    logic          r_ovf;
    logic          w_acc;
    logic          w_room;

    assign o_in_stall = i_q_stat.full;
    assign w_acc      = i_in_valid && !i_q_stat.full;
    assign w_room     = (r_fill != CW'(MAX_LEN));

    assign o_cmd.wr      = w_room;
    assign o_cmd.seq_end = i_last_symbol;
    assign o_cmd.ovf     = r_ovf || !w_room;
    assign o_cmd.sym     = i_symbol;

    // dropped symbols that do not end the sequence need no command
    assign o_push = w_acc && (w_room || i_last_symbol);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_ovf  <= 1'b0;
        end else if (w_acc) begin
            if (i_last_symbol) begin
                r_fill <= '0;
                r_ovf  <= 1'b0;
            end else if (w_room) begin
                r_fill <= r_fill + CW'(1);
            end else begin
                r_ovf  <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mfsf_fifo.sv -----
// ----------------------------------------------------------------------------
// Most frequent substring finder: command queue
// Short FIFO decoupling the front end from the search engine.
// ----------------------------------------------------------------------------
`default_nettype none

module mfsf_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    input  wire mfsf_pkg::t_cmd     i_cmd,
    input  wire logic               i_pop,
    output mfsf_pkg::t_cmd          o_head,
    output mfsf_pkg::t_q_stat       o_q_stat
);
    import mfsf_pkg::*;

    t_cmd           r_mem [QDEPTH];
    logic [QPW-1:0] r_wp;
    logic [QPW-1:0] r_rp;
    logic [QPW:0]   r_cnt;

    assign o_head         = r_mem[r_rp];
    assign o_q_stat.full  = (r_cnt == (QPW + 1)'(QDEPTH));
    assign o_q_stat.empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QPW'(1);
            end
            if (i_pop) begin
                r_rp <= r_rp + QPW'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + (QPW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - (QPW + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/mfsf_search.sv -----
// ----------------------------------------------------------------------------
// Most frequent substring finder: search engine
// Holds the symbol store and walks every start/length pair, one per cycle
// in the step state, with a parallel match vector and a registered popcount
// tree. Pass one finds the maximum count, pass two applies the length rule.
// ----------------------------------------------------------------------------
`default_nettype none

module mfsf_search #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire mfsf_pkg::t_cmd         i_head,
    input  wire mfsf_pkg::t_q_stat      i_q_stat,
    output logic                        o_pop,
    input  wire logic                   i_out_stall,
    output logic                        o_out_valid,
    output logic [$clog2(MAX_LEN+1)-1:0] o_best_count,
    output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] o_best_start,
    output logic [$clog2(MAX_LEN+1)-1:0] o_best_length,
    output logic                        o_overflowed
);
    import mfsf_pkg::*;

    localparam int IW   = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CW   = $clog2(MAX_LEN + 1);
    localparam int CW1  = CW + 1;
    localparam int NG   = (MAX_LEN + GRP_W - 1) / GRP_W;
    localparam int PADW = NG * GRP_W;

    t_srch_state r_state;
    t_srch_state n_state;

    logic [MAX_LEN-1:0][SYM_W-1:0] r_mem;
    logic [MAX_LEN-1:0][SYM_W-1:0] r_u;
    logic [MAX_LEN-1:0][SYM_W-1:0] r_w;
    logic [MAX_LEN-1:0][SYM_W-1:0] r_x;

    logic [CW-1:0]      r_n;
    logic               r_seq_ovf;
    logic               r_pass;
    logic [IW-1:0]      r_s;
    logic [CW-1:0]      r_len;

    logic [MAX_LEN-1:0] r_lim;
    logic [MAX_LEN-1:0] r_m;
    logic               r_m_vld;
    logic [IW-1:0]      r_m_s;
    logic [CW-1:0]      r_m_len;

    logic [NG-1:0][GRP_CNT_W-1:0] r_grp;
    logic               r_b_vld;
    logic [IW-1:0]      r_b_s;
    logic [CW-1:0]      r_b_len;

    logic [CW-1:0]      r_max;
    logic [IW-1:0]      r_pick_s;
    logic [CW-1:0]      r_pick_len;
    logic [IW-1:0]      r_fl_s;
    logic [CW-1:0]      r_fl_len;

    logic               r_out_vld;
    logic [CW-1:0]      r_out_count;
    logic [IW-1:0]      r_out_start;
    logic [CW-1:0]      r_out_len;
    logic               r_out_ovf;

    logic [MAX_LEN-1:0] w_eq;
    logic [PADW-1:0]    w_m_pad;
    logic [NG-1:0][GRP_CNT_W-1:0] w_grp;
    logic [CW-1:0]      w_cnt;
    logic               w_last_len;
    logic               w_last_s;
    logic               w_out_free;
    logic               w_drained;

    assign w_m_pad    = PADW'(r_m);
    assign w_last_len = ((CW1'(r_s) + CW1'(r_len)) == CW1'(r_n));
    assign w_last_s   = ((CW'(r_s) + CW'(1)) == r_n);
    assign w_out_free = !r_out_vld || !i_out_stall;
    assign w_drained  = !r_m_vld && !r_b_vld;

    always_comb begin
        for (int q = 0; q < MAX_LEN; q++) begin
            w_eq[q] = (r_w[q] == r_x[0]);
        end
    end

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            w_grp[g] = '0;
            for (int b = 0; b < GRP_W; b++) begin
                w_grp[g] = w_grp[g] + GRP_CNT_W'(w_m_pad[g*GRP_W + b]);
            end
        end
    end

    always_comb begin
        w_cnt = '0;
        for (int g = 0; g < NG; g++) begin
            w_cnt = w_cnt + CW'(r_grp[g]);
        end
    end

    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_head.seq_end) begin
                        n_state = ST_SETUP;
                    end
                end
            end
            ST_SETUP: begin
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (w_last_len && w_last_s) begin
                    n_state = ST_DRAIN;
                end else if (w_last_len) begin
                    n_state = ST_LOAD;
                end
            end
            ST_DRAIN: begin
                if (w_drained) begin
                    n_state = r_pass ? ST_FINISH : ST_SETUP;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_n       <= '0;
            r_pass    <= 1'b0;
            r_m_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_m_vld <= (r_state == ST_STEP);
            r_b_vld <= r_m_vld;
            if (o_pop && i_head.wr) begin
                r_n <= r_n + CW'(1);
            end
            if (o_pop && i_head.seq_end) begin
                r_pass <= 1'b0;
            end
            if ((r_state == ST_DRAIN) && w_drained) begin
                r_pass <= 1'b1;
            end
            if ((r_state == ST_FINISH) && w_out_free) begin
                r_n       <= '0;
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.wr) begin
            r_mem[r_n[IW-1:0]] <= i_head.sym;
        end
        if (o_pop && i_head.seq_end) begin
            r_seq_ovf  <= i_head.ovf;
            r_max      <= '0;
            r_pick_s   <= '0;
            r_pick_len <= '0;
        end
        case (r_state)
            ST_SETUP: begin
                r_u <= r_mem;
                r_s <= '0;
            end
            ST_LOAD: begin
                r_w   <= r_mem;
                r_x   <= r_u;
                r_u   <= r_u >> SYM_W;
                r_len <= CW'(1);
                r_m   <= '1;
                for (int q = 0; q < MAX_LEN; q++) begin
                    r_lim[q] <= (CW'(q) < r_n);
                end
            end
            ST_STEP: begin
                r_m     <= r_m & w_eq & r_lim;
                r_m_s   <= r_s;
                r_m_len <= r_len;
                r_w     <= r_w >> SYM_W;
                r_x     <= r_x >> SYM_W;
                r_lim   <= r_lim >> 1;
                r_len   <= r_len + CW'(1);
                if (w_last_len) begin
                    r_s <= r_s + IW'(1);
                end
            end
            ST_DRAIN: begin
                if (w_drained && !r_pass) begin
                    r_fl_s   <= r_pick_s;
                    r_fl_len <= r_pick_len;
                end
            end
            ST_FINISH: begin
                if (w_out_free) begin
                    r_out_count <= r_max;
                    r_out_start <= r_fl_s;
                    r_out_len   <= r_fl_len;
                    r_out_ovf   <= r_seq_ovf;
                end
            end
            default: begin
            end
        endcase

        r_grp   <= w_grp;
        r_b_s   <= r_m_s;
        r_b_len <= r_m_len;

        if (r_b_vld) begin
            if (!r_pass) begin
                if (w_cnt >= r_max) begin
                    r_max      <= w_cnt;
                    r_pick_s   <= r_b_s;
                    r_pick_len <= r_b_len;
                end
            end else if ((r_b_len > r_fl_len) && (w_cnt == r_max)) begin
                r_fl_s   <= r_b_s;
                r_fl_len <= r_b_len;
            end
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_best_count  = r_out_count;
    assign o_best_start  = r_out_start;
    assign o_best_length = r_out_len;
    assign o_overflowed  = r_out_ovf;

endmodule

`default_nettype wire

// ----- rtl/most_frequent_substring_finder.sv -----
// ----------------------------------------------------------------------------
// Most frequent substring finder
// Loads a byte sequence and reports the substring with the most overlapping
// occurrences, preferring the longest.
// ----------------------------------------------------------------------------
// Symbols are taken one per cycle while the command queue has room and are
// written into the store as they come; up to MAX_LEN symbols are kept and
// later ones are dropped and flagged. The transaction marked last starts the
// search, which steps through one start/length pair per cycle in its step
// state over two passes. Input transactions keep queuing during the search
// until the four-entry queue fills; the store itself is busy for the whole
// search.
// ----------------------------------------------------------------------------
`default_nettype none

`include "most_frequent_substring_finder_macros.svh"

module most_frequent_substring_finder #(
    parameter int MAX_LEN = 64
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [7:0]             i_symbol,
    input  wire logic                   i_last_symbol,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [$clog2(MAX_LEN+1)-1:0] o_best_count,
    output logic [((MAX_LEN > 1) ? $clog2(MAX_LEN) : 1)-1:0] o_best_start,
    output logic [$clog2(MAX_LEN+1)-1:0] o_best_length,
    output logic                        o_overflowed
);
    import mfsf_pkg::*;

    logic    w_push;
    logic    w_pop;
    t_cmd    w_cmd;
    t_cmd    w_head;
    t_q_stat w_q_stat;

    mfsf_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_symbol      (i_symbol),
        .i_last_symbol (i_last_symbol),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    mfsf_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_cmd    (w_cmd),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_q_stat (w_q_stat)
    );

    mfsf_search #(
        .MAX_LEN (MAX_LEN)
    ) u_search (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_q_stat      (w_q_stat),
        .o_pop         (w_pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_best_count  (o_best_count),
        .o_best_start  (o_best_start),
        .o_best_length (o_best_length),
        .o_overflowed  (o_overflowed)
    );

    `MFSF_ASSERT_IMP(a_push_not_full, w_push, !w_q_stat.full)
    `MFSF_ASSERT_IMP(a_pop_not_empty, w_pop, !w_q_stat.empty)
    `MFSF_ASSERT_NXT(a_search_holds_queue, w_pop && w_head.seq_end, !w_pop)
    `MFSF_ASSERT_IMP(a_result_nonzero, o_out_valid, (o_best_count != '0) && (o_best_length != '0))

endmodule

`default_nettype wire

// ----- dv/tb_most_frequent_substring_finder.sv -----
// ----------------------------------------------------------------------------
// Testbench: most frequent substring finder
// Sends byte sequences, predicts the most frequent substring of each one
// (greatest count, then the tie rule on length) and checks every result.
// Input and output idle at random in the first two of three phases. One phase
// holds the output off for a long stretch so that the block backs up.
// ----------------------------------------------------------------------------
module tb_most_frequent_substring_finder;
    timeunit 1ns;
    timeprecision 1ps;

    import mfsf_pkg::*;

    localparam int MAX_LEN        = 64;
    localparam int WATCHDOG_LIMIT = 50000;
    localparam int TAIL_CYCLES    = 200;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [6:0] best_count;
        logic [5:0] best_start;
        logic [6:0] best_length;
        logic       overflowed;
    } t_best_substring;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_sym       i_symbol;
    logic       i_last_symbol;
    logic       o_out_valid;
    logic       i_out_stall;
    logic [6:0] o_best_count;
    logic [5:0] o_best_start;
    logic [6:0] o_best_length;
    logic       o_overflowed;

    // predictor state
    t_sym            seq_store [MAX_LEN];
    int              seq_len;
    bit              seq_ovf;
    t_best_substring expected_results [$];

    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_left;
    int items_sent;
    int fail_count;

    most_frequent_substring_finder #(
        .MAX_LEN(MAX_LEN)
    ) uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_symbol     (i_symbol),
        .i_last_symbol(i_last_symbol),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_best_count (o_best_count),
        .o_best_start (o_best_start),
        .o_best_length(o_best_length),
        .o_overflowed (o_overflowed)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic t_best_substring predict_best_substring();
        int lcp [0:MAX_LEN][0:MAX_LEN];
        int hits [0:MAX_LEN-1][1:MAX_LEN];
        int n, s, len, pos, c;
        int max_count, pick_start, pick_len;
        t_best_substring res;
        n = seq_len;
        for (int i = 0; i <= MAX_LEN; i++) begin
            for (int j = 0; j <= MAX_LEN; j++) begin
                lcp[i][j] = 0;
            end
        end
        for (int i = n - 1; i >= 0; i--) begin
            for (int j = n - 1; j >= 0; j--) begin
                lcp[i][j] = (seq_store[i] == seq_store[j]) ? lcp[i+1][j+1] + 1 : 0;
            end
        end
        for (s = 0; s < n; s++) begin
            for (len = 1; s + len <= n; len++) begin
                c = 0;
                for (pos = 0; pos + len <= n; pos++) begin
                    if (lcp[pos][s] >= len) begin
                        c++;
                    end
                end
                hits[s][len] = c;
            end
        end
        // last in enumeration order with the top count
        max_count  = 0;
        pick_start = 0;
        pick_len   = 0;
        for (s = 0; s < n; s++) begin
            for (len = 1; s + len <= n; len++) begin
                if (hits[s][len] >= max_count) begin
                    max_count  = hits[s][len];
                    pick_start = s;
                    pick_len   = len;
                end
            end
        end
        // each strictly longer one with the same count takes over in turn
        for (s = 0; s < n; s++) begin
            for (len = 1; s + len <= n; len++) begin
                if (len > pick_len && hits[s][len] == max_count) begin
                    pick_len   = len;
                    pick_start = s;
                end
            end
        end
        res.best_count  = max_count[6:0];
        res.best_start  = pick_start[5:0];
        res.best_length = pick_len[6:0];
        res.overflowed  = seq_ovf;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------
    task automatic push_symbol(input t_sym sym, input bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_symbol      = sym;
        i_last_symbol = last;
        do @(posedge i_clk); while (o_in_stall);
        items_sent++;
        if (seq_len < MAX_LEN) begin
            seq_store[seq_len] = sym;
            seq_len++;
        end else begin
            seq_ovf = 1'b1;
        end
        if (last) begin
            expected_results = {expected_results, predict_best_substring()};
            seq_len = 0;
            seq_ovf = 1'b0;
        end
    endtask

    // first symbol in the top byte of the used part
    task automatic send_bytes(input logic [8*8-1:0] bytes, input int len);
        for (int i = 0; i < len; i++) begin
            push_symbol(bytes[8*(len-1-i) +: 8], i == len - 1);
        end
    endtask

    // alpha_size of zero draws from the full byte range
    task automatic send_sequence(input int len, input int alpha_size);
        t_sym alphabet [4];
        t_sym sym;
        for (int i = 0; i < 4; i++) begin
            alphabet[i] = t_sym'($urandom_range(255));
        end
        for (int i = 0; i < len; i++) begin
            if (alpha_size == 0) begin
                sym = t_sym'($urandom_range(255));
            end else begin
                sym = alphabet[$urandom_range(alpha_size - 1)];
            end
            push_symbol(sym, i == len - 1);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_left > 0) begin
                i_out_stall = 1'b1;
                rx_hold_left--;
            end else begin
                i_out_stall = ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    task automatic note_failure(input string what, input int want, input int got);
        if (fail_count < MAX_REPORTS) begin
            $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
        end
        fail_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_best_substring want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                note_failure("unexpected result transaction, best_count", 0, o_best_count);
            end else begin
                want = expected_results.pop_front();
                if (o_best_count !== want.best_count)
                    note_failure("best_count", want.best_count, o_best_count);
                if (o_best_start !== want.best_start)
                    note_failure("best_start", want.best_start, o_best_start);
                if (o_best_length !== want.best_length)
                    note_failure("best_length", want.best_length, o_best_length);
                if (o_overflowed !== want.overflowed)
                    note_failure("overflowed", want.overflowed, o_overflowed);
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    task automatic test_directed();
        send_bytes(64'h00, 1);
        send_bytes(64'hFF, 1);
        send_bytes(64'hAAAA_AAAA, 4);            // one repeated symbol
        send_bytes(64'h6162_6162, 4);            // tie, longer substring wins
        send_bytes(64'h01_0204_807F, 5);         // all distinct
        send_bytes(64'h6161_6261_6162, 6);
    endtask

    task automatic test_store_full();
        send_sequence(MAX_LEN, 2);               // exactly full
        send_sequence(MAX_LEN + 1, 3);           // last symbol dropped
        send_sequence(MAX_LEN + 6, 0);
        send_sequence(MAX_LEN + 2, 1);
    endtask

    task automatic test_random_sequences(input int item_goal);
        int stop_at, r, len;
        stop_at = items_sent + item_goal;
        while (items_sent < stop_at) begin
            r = $urandom_range(99);
            if (r < 70)      len = $urandom_range(8, 1);
            else if (r < 93) len = $urandom_range(24, 9);
            else if (r < 98) len = $urandom_range(MAX_LEN - 1, 25);
            else             len = $urandom_range(MAX_LEN + 6, MAX_LEN);
            send_sequence(len, $urandom_range(4));
        end
    endtask

    task automatic test_output_backpressure();
        rx_hold_left = 1500;
        for (int i = 0; i < 12; i++) begin
            send_sequence($urandom_range(3, 1), $urandom_range(4));
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_symbol      = '0;
        i_last_symbol = 1'b0;
        seq_len       = 0;
        seq_ovf       = 1'b0;
        items_sent    = 0;
        fail_count    = 0;
        rx_hold_left  = 0;
        tx_idle_pct   = 7;
        rx_stall_pct  = 70;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_sequences(420);
        test_output_backpressure();
        wait_drained();

        tx_idle_pct  = 70;
        rx_stall_pct = 7;
        test_store_full();
        test_random_sequences(420);
        wait_drained();

        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        test_random_sequences(420);
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/mfsf_pkg.sv
rtl/mfsf_front.sv
rtl/mfsf_fifo.sv
rtl/mfsf_search.sv
rtl/most_frequent_substring_finder.sv
dv/tb_most_frequent_substring_finder.sv
